>>> src/serial_line_discipline_defines.svh
// ----------------------------------------------------------------------------
// serial line discipline assertion macros
// shared concurrent check wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_DISCIPLINE_DEFINES_SVH
`define SERIAL_LINE_DISCIPLINE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen out of reset
`define SLD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SLD_ASSERT(lbl, clk, rst, prop, msg)
`define SLD_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

>>> src/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// types and constants shared by the serial line discipline modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sld_pkg;

  // result channel codes
  localparam logic [1:0] CH_ECHO  = 2'd0;
  localparam logic [1:0] CH_READ  = 2'd1;
  localparam logic [1:0] CH_EMPTY = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BRKT  = 8'h5B;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] UTF_LEAD   = 8'b1100_0000;
  localparam logic [7:0] UTF_CONT   = 8'b1000_0000;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;

  // register byte addresses (word decode on bit 2)
  localparam logic REG_LINE_MODE = 1'b0;

  // command from front to back
  typedef struct packed {
    logic       is_read;
    logic [7:0] ch;
    logic [5:0] max_len;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] data;
    logic [5:0] count;
    logic       last;
    logic       overflow;
  } res_t;

  // echo sequence kind
  typedef enum logic [1:0] {
    ECHO_ERASE = 2'b01,
    ECHO_CHAR  = 2'b10
  } echo_kind_t;

  // byte idx of an echo sequence
  function automatic logic [7:0] echo_byte(echo_kind_t kind, logic [7:0] ch,
                                           logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (kind == ECHO_ERASE) begin
      case (idx)
        3'd0, 3'd4: b = CHAR_ESC;
        3'd1, 3'd5: b = CHAR_BRKT;
        3'd2, 3'd6: b = CHAR_D;
        3'd3:       b = CHAR_SPACE;
        default:    b = 8'h00;
      endcase
    end else if (idx == 3'd0) begin
      b = ch[7] ? (UTF_LEAD | {6'd0, ch[7:6]}) : ch;
    end else begin
      b = ch[7] ? (UTF_CONT | (ch & LOW6_MASK)) : CHAR_LF;
    end
    return b;
  endfunction

endpackage

>>> src/sld_fifo.sv
// ----------------------------------------------------------------------------
// sld_fifo
// small synchronous queue used between stages and at the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  // handshake qualifiers
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/sld_front.sv
// ----------------------------------------------------------------------------
// sld_front
// takes requests, handles escape skip and lead bytes, issues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_front
  import sld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       line_mode,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [5:0] max_len,
  output logic       cmd_push,
  output cmd_t       cmd,
  input  logic       cmd_full
);

  logic [1:0] skip_left;
  logic       lead_pending;
  logic [7:0] lead_byte;
  logic       take;
  logic [7:0] ch;
  logic       is_char;

  assign full = cmd_full;
  assign take = push && !cmd_full;

  // classify the request
  always_comb begin
    ch      = lead_pending ? {lead_byte[1:0], rx_byte[5:0]} : rx_byte;
    is_char = !req_type && (skip_left == 2'd0) && (lead_pending || !rx_byte[7]);
    cmd_push    = take && (req_type || (is_char && !(line_mode && ch == CHAR_ESC)));
    cmd.is_read = req_type;
    cmd.ch      = ch;
    cmd.max_len = max_len;
  end

  // skip and lead state
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left    <= 2'd0;
      lead_pending <= 1'b0;
      lead_byte    <= 8'd0;
    end else if (take && !req_type) begin
      if (skip_left != 2'd0) begin
        skip_left <= skip_left - 2'd1;
      end else if (!lead_pending && rx_byte[7]) begin
        lead_pending <= 1'b1;
        lead_byte    <= rx_byte;
      end else begin
        lead_pending <= 1'b0;
        if (line_mode && ch == CHAR_ESC) begin
          skip_left <= 2'd2;
        end
      end
    end
  end

endmodule

>>> src/sld_back.sv
// ----------------------------------------------------------------------------
// sld_back
// character store, echo generation and read sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_line_discipline_defines.svh"

module sld_back
  import sld_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic line_mode,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_push,
  output res_t out_res,
  input  logic out_full
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_ECHO     = 8'b0000_0100,
    ST_EMPTY    = 8'b0000_1000,
    ST_SCAN_RD  = 8'b0001_0000,
    ST_SCAN_CHK = 8'b0010_0000,
    ST_EMIT_RD  = 8'b0100_0000,
    ST_EMIT_OUT = 8'b1000_0000
  } state_t;

  state_t      state;
  cmd_t        cmd_r;
  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  mem_q;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [FW-1:0] lim;
  logic [FW-1:0] cnt;
  logic [2:0]  echo_idx;
  logic [2:0]  echo_len;
  echo_kind_t  echo_kind;
  logic        ovf;
  logic        store_c;
  logic        full_c;
  logic [FW-1:0] n_c;
  logic [FW-1:0] lim_c;
  logic        last_item;
  logic [FW:0] tail_sum;
  logic [PW-1:0] tail_chk;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(BUFFER_DEPTH - 1) : p - 1'b1;
  endfunction

  // decode helpers
  assign full_c    = (fill == FW'(BUFFER_DEPTH));
  assign n_c       = (cmd_r.max_len > 6'(BUFFER_DEPTH)) ? FW'(BUFFER_DEPTH)
                                                        : FW'(cmd_r.max_len);
  assign lim_c     = (n_c < fill) ? n_c : fill;
  assign store_c   = (state == ST_DECODE) && !cmd_r.is_read && !full_c &&
                     (!line_mode || cmd_r.ch != CHAR_DEL);
  assign last_item = (idx == cnt - 1'b1);
  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (store_c) begin
      mem[tail] <= cmd_r.ch;
    end
    if (state == ST_SCAN_RD || state == ST_EMIT_RD) begin
      mem_q <= mem[rd_ptr];
    end
  end

  // result item
  always_comb begin
    out_push = 1'b0;
    out_res  = '0;
    case (state)
      ST_ECHO: begin
        out_push         = !out_full;
        out_res.channel  = CH_ECHO;
        out_res.data     = echo_byte(echo_kind, cmd_r.ch, echo_idx);
        out_res.last     = (echo_idx == echo_len - 3'd1);
        out_res.overflow = ovf;
      end
      ST_EMPTY: begin
        out_push        = !out_full;
        out_res.channel = CH_EMPTY;
        out_res.last    = 1'b1;
      end
      ST_EMIT_OUT: begin
        out_push        = !out_full;
        out_res.channel = CH_READ;
        out_res.data    = (line_mode && last_item) ? CHAR_LF : mem_q;
        out_res.count   = last_item ? 6'(cnt) : 6'd0;
        out_res.last    = last_item;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd_r <= cmd;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          echo_idx <= 3'd0;
          idx      <= '0;
          rd_ptr   <= head;
          lim      <= lim_c;
          cnt      <= lim_c;
          if (store_c) begin
            tail <= ptr_inc(tail);
            fill <= fill + 1'b1;
          end
          if (cmd_r.is_read) begin
            if (fill == '0 || (!line_mode && lim_c == '0)) begin
              state <= ST_EMPTY;
            end else if (!line_mode) begin
              state <= ST_EMIT_RD;
            end else begin
              state <= ST_SCAN_RD;
            end
          end else if (!line_mode) begin
            state <= ST_IDLE;
          end else if (cmd_r.ch == CHAR_DEL) begin
            echo_kind <= ECHO_ERASE;
            echo_len  <= 3'd7;
            ovf       <= 1'b0;
            if (fill != '0) begin
              fill  <= fill - 1'b1;
              tail  <= ptr_dec(tail);
              state <= ST_ECHO;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            echo_kind <= ECHO_CHAR;
            echo_len  <= (cmd_r.ch[7] || cmd_r.ch == CHAR_CR) ? 3'd2 : 3'd1;
            ovf       <= full_c;
            state     <= ST_ECHO;
          end
        end
        ST_ECHO: begin
          if (!out_full) begin
            if (echo_idx == echo_len - 3'd1) begin
              state <= ST_IDLE;
            end else begin
              echo_idx <= echo_idx + 3'd1;
            end
          end
        end
        ST_EMPTY: begin
          if (!out_full) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          if (idx == lim) begin
            if (lim == fill) begin
              state <= ST_EMPTY;
            end else begin
              cnt    <= idx + 1'b1;
              idx    <= '0;
              rd_ptr <= head;
              state  <= ST_EMIT_RD;
            end
          end else begin
            state <= ST_SCAN_CHK;
          end
        end
        ST_SCAN_CHK: begin
          if (mem_q == CHAR_CR) begin
            cnt    <= idx + 1'b1;
            idx    <= '0;
            rd_ptr <= head;
            state  <= ST_EMIT_RD;
          end else begin
            idx    <= idx + 1'b1;
            rd_ptr <= ptr_inc(rd_ptr);
            state  <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (!out_full) begin
            if (last_item) begin
              head  <= ptr_inc(rd_ptr);
              fill  <= fill - cnt;
              state <= ST_IDLE;
            end else begin
              idx    <= idx + 1'b1;
              rd_ptr <= ptr_inc(rd_ptr);
              state  <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // expected write pointer from head and fill
  assign tail_sum = {1'b0, FW'(head)} + {1'b0, fill};
  assign tail_chk = (tail_sum >= (FW + 1)'(BUFFER_DEPTH))
                    ? PW'(tail_sum - (FW + 1)'(BUFFER_DEPTH)) : PW'(tail_sum);

  `SLD_ASSERT_NEVER(a_fill_bound, clk, rst, fill > FW'(BUFFER_DEPTH), "fill above depth")
  `SLD_ASSERT(a_tail_track, clk, rst, tail == tail_chk, "write pointer out of step")
  `SLD_ASSERT(a_push_room, clk, rst, out_push |-> !out_full, "result pushed into full queue")
  `SLD_ASSERT(a_emit_range, clk, rst, (state == ST_EMIT_OUT) |-> (idx < cnt), "read index past count")

endmodule

>>> src/serial_line_discipline.sv
// ----------------------------------------------------------------------------
// serial_line_discipline
// tty style line discipline: echo, line editing and read delivery
// ----------------------------------------------------------------------------
// channel   side    handshake               payload
// request   in      push / full             req_type, rx_byte, max_len
// result    out     pop / empty             channel, data_byte, read_count,
//                                           last, overflow
// config    in/out  psel penable pwrite     paddr, pwdata, prdata (line_mode)
//
// every command passes through take and decode in the back before its work
// a received byte then yields one echo byte per cycle unless stalled (none to 7)
// a canonical read scans the store a character at a time, then sends each byte;
// a raw read only sends; each step reads the store, so its read port sets the pace
// one command is worked at a time; a 2-entry queue decouples front and back
// a stalled result side stops the back, the front keeps taking requests
// until the command queue fills; reset is synchronous and empties the store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_discipline
  import sld_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [5:0]  max_len,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  channel,
  output logic [7:0]  data_byte,
  output logic [5:0]  read_count,
  output logic        last,
  output logic        overflow
);

  logic line_mode;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic out_push;
  logic out_full;
  res_t out_res;
  res_t res_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_MODE) ? {31'd0, line_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_LINE_MODE) begin
      line_mode <= pwdata[0];
    end
  end

  // front: classify requests
  sld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .line_mode (line_mode),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .max_len   (max_len),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  // command queue
  sld_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // back: store, echo and reads
  sld_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .line_mode (line_mode),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_push  (out_push),
    .out_res   (out_res),
    .out_full  (out_full)
  );

  // result queue
  sld_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign channel    = res_q.channel;
  assign data_byte  = res_q.data;
  assign read_count = res_q.count;
  assign last       = res_q.last;
  assign overflow   = res_q.overflow;

endmodule
